// ===== hw/rtl/rcm_pkg.sv =====
// Shared types and constants for the RC stick channel mapper.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package rcm_pkg;

   localparam int unsigned PULSE_W = 16;
   localparam int unsigned CMD_W   = 16;
   localparam int unsigned NUM_CH  = 8;
   localparam int unsigned MAP_W   = 2;
   localparam int unsigned BAND_W  = 9;
   localparam int unsigned TDATA_W = PULSE_W * NUM_CH;

   localparam int unsigned CENTER_US    = 1500;
   localparam int unsigned HALF_SPAN_US = 500;
   localparam int unsigned LOW_US       = 1000;
   localparam int unsigned FULL_SPAN_US = 1000;

   // floor(x / 125) == (x * RECIP_125) >> RECIP_SHIFT for x below ~490k
   localparam int unsigned RECIP_125   = 67109;
   localparam int unsigned RECIP_SHIFT = 23;
   localparam int unsigned MULC_W      = 24;

   localparam logic [MAP_W-1:0] MAP_AETR    = 2'd0;
   localparam logic [MAP_W-1:0] MAP_TAER    = 2'd1;
   localparam logic [MAP_W-1:0] MAP_SURFACE = 2'd2;

   localparam logic CSR_CHANNEL_MAP = 1'b0;
   localparam logic CSR_DEADBAND_US = 1'b1;

   localparam logic [MAP_W-1:0]  CHANNEL_MAP_RESET = MAP_AETR;
   localparam logic [BAND_W-1:0] DEADBAND_RESET    = 9'd4;

   typedef struct packed {
      logic [MAP_W-1:0]  channel_map;
      logic [BAND_W-1:0] deadband_us;
   } cfg_type;

   // Last member sits in the lowest bits, so roll_cmd lands in bits [15:0].
   typedef struct packed {
      logic signed [CMD_W-1:0] aux_four;
      logic signed [CMD_W-1:0] aux_three;
      logic signed [CMD_W-1:0] aux_two;
      logic signed [CMD_W-1:0] aux_one;
      logic signed [CMD_W-1:0] throttle_cmd;
      logic signed [CMD_W-1:0] yaw_cmd;
      logic signed [CMD_W-1:0] pitch_cmd;
      logic signed [CMD_W-1:0] roll_cmd;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rcm_norm_bi.sv =====
// Bidirectional pulse normalizer: 1500 +/- 500 us to +/- ONE with center deadband.
// Depends on rcm_pkg.
`default_nettype none

module rcm_norm_bi #(
   parameter int unsigned FRAC_BITS = 14
) (
   input  wire logic [rcm_pkg::PULSE_W-1:0] pulse,
   input  wire logic [rcm_pkg::BAND_W-1:0]  band,
   output logic signed [rcm_pkg::CMD_W-1:0] cmd
);

   // d * 2^F / 500 == a * 2^(F-2) / 125 with 2^(F-2) = 125*QUO + REM
   localparam longint unsigned ONE   = 64'd1 << FRAC_BITS;
   localparam longint unsigned SCALE = 64'd1 << (FRAC_BITS - 2);
   localparam longint unsigned QUO   = SCALE / 125;
   localparam longint unsigned REM   = SCALE % 125;
   localparam longint unsigned MULC  = REM * rcm_pkg::RECIP_125;

   localparam logic [rcm_pkg::CMD_W-1:0]  ONE16   = ONE[rcm_pkg::CMD_W-1:0];
   localparam logic [rcm_pkg::CMD_W-1:0]  QUO16   = QUO[rcm_pkg::CMD_W-1:0];
   localparam logic [rcm_pkg::MULC_W-1:0] MULC24  = MULC[rcm_pkg::MULC_W-1:0];
   localparam logic [16:0]                CENTER  = 17'(rcm_pkg::CENTER_US);
   localparam logic signed [17:0]         CENTER_S = 18'(rcm_pkg::CENTER_US);
   localparam logic signed [17:0]         SPAN_S   = 18'(rcm_pkg::HALF_SPAN_US);

   logic [16:0]        win_lo;
   logic [16:0]        win_hi;
   logic               in_band;
   logic signed [17:0] diff;
   logic signed [17:0] neg_diff;
   logic [8:0]         mag;
   logic [32:0]        frac_prod;
   logic [8:0]         frac;
   logic [15:0]        whole;
   logic [15:0]        quot;
   logic [15:0]        result;

   always_comb begin
      win_lo   = CENTER - {8'd0, band};
      win_hi   = CENTER + {8'd0, band};
      in_band  = ({1'b0, pulse} > win_lo) && ({1'b0, pulse} < win_hi);
      diff     = signed'({2'b00, pulse}) - CENTER_S;
      neg_diff = -diff;
      mag      = diff[17] ? neg_diff[8:0] : diff[8:0];
      frac_prod = 33'(mag) * 33'(MULC24);
      frac     = frac_prod[rcm_pkg::RECIP_SHIFT +: 9];
      whole    = 16'({7'd0, mag} * QUO16);
      quot     = whole + {7'd0, frac};
      if (in_band) begin
         result = '0;
      end else if (diff >= SPAN_S) begin
         result = ONE16;
      end else if (diff <= -SPAN_S) begin
         result = 16'd0 - ONE16;
      end else if (diff[17]) begin
         result = 16'd0 - quot;
      end else begin
         result = quot;
      end
   end

   assign cmd = signed'(result);

endmodule

`default_nettype wire

// ===== hw/rtl/rcm_norm_uni.sv =====
// Unidirectional pulse normalizer: 1000..2000 us to 0..ONE, clamped.
// Depends on rcm_pkg.
`default_nettype none

module rcm_norm_uni #(
   parameter int unsigned FRAC_BITS = 14
) (
   input  wire logic [rcm_pkg::PULSE_W-1:0] pulse,
   output logic signed [rcm_pkg::CMD_W-1:0] cmd
);

   // d * 2^F / 1000 == d * 2^(F-3) / 125
   localparam longint unsigned ONE   = 64'd1 << FRAC_BITS;
   localparam longint unsigned SCALE = 64'd1 << (FRAC_BITS - 3);
   localparam longint unsigned QUO   = SCALE / 125;
   localparam longint unsigned REM   = SCALE % 125;
   localparam longint unsigned MULC  = REM * rcm_pkg::RECIP_125;

   localparam logic [rcm_pkg::CMD_W-1:0]  ONE16  = ONE[rcm_pkg::CMD_W-1:0];
   localparam logic [rcm_pkg::CMD_W-1:0]  QUO16  = QUO[rcm_pkg::CMD_W-1:0];
   localparam logic [rcm_pkg::MULC_W-1:0] MULC24 = MULC[rcm_pkg::MULC_W-1:0];
   localparam logic signed [17:0]         LOW_S  = 18'(rcm_pkg::LOW_US);
   localparam logic signed [17:0]         SPAN_S = 18'(rcm_pkg::FULL_SPAN_US);

   logic signed [17:0] diff;
   logic [9:0]         mag;
   logic [33:0]        frac_prod;
   logic [9:0]         frac;
   logic [15:0]        whole;
   logic [15:0]        result;

   always_comb begin
      diff      = signed'({2'b00, pulse}) - LOW_S;
      mag       = diff[9:0];
      frac_prod = 34'(mag) * 34'(MULC24);
      frac      = frac_prod[rcm_pkg::RECIP_SHIFT +: 10];
      whole     = 16'({6'd0, mag} * QUO16);
      if (diff <= 18'sd0) begin
         result = '0;
      end else if (diff >= SPAN_S) begin
         result = ONE16;
      end else begin
         result = whole + {6'd0, frac};
      end
   end

   assign cmd = signed'(result);

endmodule

`default_nettype wire

// ===== hw/rtl/rcm_frame_map.sv =====
// Combinational frame mapping: normalizes all channels and routes them by stick order.
// Depends on rcm_pkg, rcm_norm_bi and rcm_norm_uni.
`default_nettype none

module rcm_frame_map #(
   parameter int unsigned FRAC_BITS = 14
) (
   input  wire logic [rcm_pkg::NUM_CH-1:0][rcm_pkg::PULSE_W-1:0] pulse,
   input  wire logic                                              link_connected,
   input  wire rcm_pkg::cfg_type                                  cfg,
   output rcm_pkg::cmd_type                                       cmd
);

   localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
   localparam logic [rcm_pkg::CMD_W-1:0] NEG_ONE16 = 16'd0 - ONE[rcm_pkg::CMD_W-1:0];

   logic signed [rcm_pkg::CMD_W-1:0] bi_cmd [rcm_pkg::NUM_CH];
   logic signed [rcm_pkg::CMD_W-1:0] uni_ch1;
   logic signed [rcm_pkg::CMD_W-1:0] uni_ch3;

   for (genvar i = 0; i < rcm_pkg::NUM_CH; i++) begin : g_bi
      // aux channels (5..8) have no deadband
      rcm_norm_bi #(.FRAC_BITS(FRAC_BITS)) u_bi (
         .pulse (pulse[i]),
         .band  ((i < 4) ? cfg.deadband_us : '0),
         .cmd   (bi_cmd[i])
      );
   end

   rcm_norm_uni #(.FRAC_BITS(FRAC_BITS)) u_uni_ch1 (
      .pulse (pulse[0]),
      .cmd   (uni_ch1)
   );

   rcm_norm_uni #(.FRAC_BITS(FRAC_BITS)) u_uni_ch3 (
      .pulse (pulse[2]),
      .cmd   (uni_ch3)
   );

   always_comb begin
      cmd.aux_one   = bi_cmd[4];
      cmd.aux_two   = bi_cmd[5];
      cmd.aux_three = bi_cmd[6];
      cmd.aux_four  = bi_cmd[7];
      unique case (cfg.channel_map)
         rcm_pkg::MAP_SURFACE: begin
            cmd.roll_cmd     = bi_cmd[0];
            cmd.pitch_cmd    = '0;
            cmd.yaw_cmd      = '0;
            cmd.throttle_cmd = bi_cmd[1];
         end
         rcm_pkg::MAP_TAER: begin
            cmd.throttle_cmd = uni_ch1;
            cmd.roll_cmd     = bi_cmd[1];
            cmd.pitch_cmd    = bi_cmd[2];
            cmd.yaw_cmd      = bi_cmd[3];
         end
         default: begin
            // AETR, also the unused code
            cmd.roll_cmd     = bi_cmd[0];
            cmd.pitch_cmd    = bi_cmd[1];
            cmd.throttle_cmd = uni_ch3;
            cmd.yaw_cmd      = bi_cmd[3];
         end
      endcase
      if (!link_connected) begin
         cmd.roll_cmd     = '0;
         cmd.pitch_cmd    = '0;
         cmd.yaw_cmd      = '0;
         cmd.throttle_cmd = '0;
         cmd.aux_one      = signed'(NEG_ONE16);
         cmd.aux_two      = signed'(NEG_ONE16);
         cmd.aux_three    = signed'(NEG_ONE16);
         cmd.aux_four     = signed'(NEG_ONE16);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rc_stick_channel_mapper_core.sv =====
// A request goes from accept to rsp_tvalid through the input register, mapping
// logic and result register. Throughput: one request per cycle unless rsp_tready
// stalls; the result register lets a new request in while a result waits for rsp_tready.
// Reset (synchronous): clears both valid flags, channel_map to AETR, deadband_us to 4.
// Depends on rcm_pkg and rcm_frame_map.
`default_nettype none

module rc_stick_channel_mapper_core #(
   parameter int unsigned FRAC_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // ch1_pulse, ch2_pulse, ... ch8_pulse, 16 bits each from bit 0 up
   input  wire logic [rcm_pkg::TDATA_W-1:0]   req_tdata,
   // link_connected
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, aux_one .. aux_four, 16 bits each
   output logic [rcm_pkg::TDATA_W-1:0]        rsp_tdata,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [rcm_pkg::BAND_W-1:0]    csr_wdata
);

   logic                                               stage_valid_ff;
   logic                                               stage_valid_in;
   logic [rcm_pkg::NUM_CH-1:0][rcm_pkg::PULSE_W-1:0]   stage_pulse_ff;
   logic [rcm_pkg::NUM_CH-1:0][rcm_pkg::PULSE_W-1:0]   stage_pulse_in;
   logic                                               stage_link_ff;
   logic                                               stage_link_in;
   logic                                               rsp_valid_ff;
   logic                                               rsp_valid_in;
   rcm_pkg::cmd_type                                   rsp_data_ff;
   rcm_pkg::cmd_type                                   rsp_data_in;
   rcm_pkg::cfg_type                                   cfg_ff;
   rcm_pkg::cfg_type                                   cfg_in;
   rcm_pkg::cmd_type                                   map_cmd;
   logic                                               out_ready;
   logic                                               stage_move;
   logic                                               req_take;

   rcm_frame_map #(.FRAC_BITS(FRAC_BITS)) u_frame_map (
      .pulse          (stage_pulse_ff),
      .link_connected (stage_link_ff),
      .cfg            (cfg_ff),
      .cmd            (map_cmd)
   );

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign stage_move = stage_valid_ff && out_ready;
   assign req_tready = !stage_valid_ff || out_ready;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = req_take || (stage_valid_ff && !out_ready);
      stage_pulse_in = req_take ? req_tdata : stage_pulse_ff;
      stage_link_in  = req_take ? req_tuser : stage_link_ff;
      rsp_valid_in   = stage_move || (rsp_valid_ff && !rsp_tready);
      rsp_data_in    = stage_move ? map_cmd : rsp_data_ff;
      cfg_in         = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rcm_pkg::CSR_CHANNEL_MAP: cfg_in.channel_map = csr_wdata[rcm_pkg::MAP_W-1:0];
            rcm_pkg::CSR_DEADBAND_US: cfg_in.deadband_us = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         cfg_ff.channel_map <= rcm_pkg::CHANNEL_MAP_RESET;
         cfg_ff.deadband_us <= rcm_pkg::DEADBAND_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         cfg_ff         <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_pulse_ff <= stage_pulse_in;
      stage_link_ff  <= stage_link_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rcm_checker.sv =====
// Port-level checks for rc_stick_channel_mapper_core, attached by bind.
// Depends on rcm_pkg for the data width.
`default_nettype none

module rcm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [rcm_pkg::TDATA_W-1:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // an empty result register means the input stage can always move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while result register empty");

   // a response appearing from idle comes from a request that passed the input and result registers
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without matching request");

endmodule

bind rc_stick_channel_mapper_core rcm_checker u_rcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/tb_rc_stick_channel_mapper_core.sv =====
// Self-checking testbench for rc_stick_channel_mapper_core: drives receiver frames,
// predicts the eight stick commands per frame and checks them in order.
// Depends on rcm_pkg and the mapper RTL.
`timescale 1ns / 1ps

module tb_rc_stick_channel_mapper_core;

   localparam int FRAC_BITS   = 14;
   localparam int ONE         = 1 << FRAC_BITS;
   localparam int CENTER      = 1500;
   localparam int HALF_SPAN   = 500;
   localparam int LOW_END     = 1000;
   localparam int FULL_SPAN   = 1000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 7;
   localparam int LONG_STALL  = 300;

   // code 3 is not assigned and decodes like AETR
   localparam logic [rcm_pkg::MAP_W-1:0] MAP_UNUSED = 2'd3;

   typedef struct packed {
      logic                           link;
      logic [rcm_pkg::TDATA_W-1:0]    pulses;
   } frame_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   wire logic                      req_tready;
   logic [rcm_pkg::TDATA_W-1:0]    req_tdata = '0;
   logic                           req_tuser = 1'b0;
   wire logic                      rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   wire logic [rcm_pkg::TDATA_W-1:0] rsp_tdata;
   logic                           csr_we = 1'b0;
   logic                           csr_index = 1'b0;
   logic [rcm_pkg::BAND_W-1:0]     csr_wdata = '0;

   // mirror of the mapper's registers, reset values
   logic [rcm_pkg::MAP_W-1:0]      map_setting = rcm_pkg::MAP_AETR;
   logic [rcm_pkg::BAND_W-1:0]     band_setting = 9'd4;

   frame_type                      frames_to_send[$];
   frame_type                      next_frame;
   rcm_pkg::cmd_type               pending_cmds[$];
   int                             frames_queued = 0;
   int                             frames_taken = 0;
   int                             cycle_count = 0;
   int                             error_count = 0;
   int                             send_idle_pct = 0;
   int                             stall_pct = 0;
   int                             stall_left = 0;
   logic                           req_fire = 1'b0;
   logic                           stall_ask = 1'b0;
   logic                           stall_ack = 1'b0;

   string cmd_names[8] = '{"roll_cmd", "pitch_cmd", "yaw_cmd", "throttle_cmd",
                           "aux_one", "aux_two", "aux_three", "aux_four"};

   logic [rcm_pkg::MAP_W-1:0]  phase_map[NUM_PHASES] = '{rcm_pkg::MAP_TAER,
      rcm_pkg::MAP_SURFACE, MAP_UNUSED, rcm_pkg::MAP_AETR, rcm_pkg::MAP_TAER,
      rcm_pkg::MAP_SURFACE, rcm_pkg::MAP_AETR};
   logic [rcm_pkg::BAND_W-1:0] phase_band[NUM_PHASES] = '{9'd0, 9'd500, 9'd511, 9'd1,
      9'd25, 9'd0, 9'd500};
   int phase_send_idle[NUM_PHASES] = '{49, 0, 37, 0, 37, 49, 0};
   int phase_stall[NUM_PHASES]     = '{0, 49, 37, 0, 37, 0, 49};

   rc_stick_channel_mapper_core #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic signed [15:0] stick_bipolar(input logic [15:0] pulse,
                                                        input int band);
      int p;
      int d;
      p = pulse;
      if (p > CENTER - band && p < CENTER + band) return 16'sd0;
      d = p - CENTER;
      if (d >= HALF_SPAN) return 16'(ONE);
      if (d <= -HALF_SPAN) return 16'(-ONE);
      return 16'((d * ONE) / HALF_SPAN);
   endfunction

   function automatic logic signed [15:0] throttle_unipolar(input logic [15:0] pulse);
      int d;
      d = int'(pulse) - LOW_END;
      if (d <= 0) return 16'sd0;
      if (d >= FULL_SPAN) return 16'(ONE);
      return 16'((d * ONE) / FULL_SPAN);
   endfunction

   function automatic rcm_pkg::cmd_type map_frame(input logic [rcm_pkg::TDATA_W-1:0] pulses,
                                                  input logic link);
      rcm_pkg::cmd_type cmd;
      logic [15:0]      ch[8];
      int               band;
      for (int k = 0; k < 8; k++) ch[k] = pulses[16*k +: 16];
      band = band_setting;
      cmd = '0;
      if (!link) begin
         cmd.aux_one   = 16'(-ONE);
         cmd.aux_two   = 16'(-ONE);
         cmd.aux_three = 16'(-ONE);
         cmd.aux_four  = 16'(-ONE);
         return cmd;
      end
      case (map_setting)
         rcm_pkg::MAP_SURFACE: begin
            cmd.roll_cmd     = stick_bipolar(ch[0], band);
            cmd.throttle_cmd = stick_bipolar(ch[1], band);
         end
         rcm_pkg::MAP_TAER: begin
            cmd.throttle_cmd = throttle_unipolar(ch[0]);
            cmd.roll_cmd     = stick_bipolar(ch[1], band);
            cmd.pitch_cmd    = stick_bipolar(ch[2], band);
            cmd.yaw_cmd      = stick_bipolar(ch[3], band);
         end
         default: begin
            cmd.roll_cmd     = stick_bipolar(ch[0], band);
            cmd.pitch_cmd    = stick_bipolar(ch[1], band);
            cmd.throttle_cmd = throttle_unipolar(ch[2]);
            cmd.yaw_cmd      = stick_bipolar(ch[3], band);
         end
      endcase
      // aux channels never get a deadband
      cmd.aux_one   = stick_bipolar(ch[4], 0);
      cmd.aux_two   = stick_bipolar(ch[5], 0);
      cmd.aux_three = stick_bipolar(ch[6], 0);
      cmd.aux_four  = stick_bipolar(ch[7], 0);
      return cmd;
   endfunction

   // weighted toward the deadband edges, the clamp points and the center
   function automatic logic [15:0] pick_pulse();
      int b;
      int off;
      b = band_setting;
      off = int'($urandom_range(6)) - 3;
      case ($urandom_range(9))
         0, 1: return 16'($urandom);
         2: return 16'(CENTER - b + off);
         3: return 16'(CENTER + b + off);
         4: return 16'((($urandom_range(1) != 0) ? 2000 : 1000) + off);
         5: return 16'(CENTER + HALF_SPAN * (($urandom_range(1) != 0) ? 1 : -1) + off);
         6: return 16'(CENTER + off);
         default: return 16'(700 + int'($urandom_range(1600)));
      endcase
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_frame(input logic [rcm_pkg::TDATA_W-1:0] pulses, input logic link);
      frame_type f;
      f.pulses = pulses;
      f.link = link;
      frames_to_send.push_back(f);
      frames_queued++;
   endtask

   task automatic add_random_frames(input int count);
      logic [rcm_pkg::TDATA_W-1:0] pulses;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 8; k++) pulses[16*k +: 16] = pick_pulse();
         add_frame(pulses, $urandom_range(9) != 0);
      end
   endtask

   task automatic write_csr(input logic idx, input logic [rcm_pkg::BAND_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == rcm_pkg::CSR_CHANNEL_MAP) begin
         map_setting = value[rcm_pkg::MAP_W-1:0];
      end else begin
         band_setting = value;
      end
   endtask

   // wait until every queued request went in and every command came back
   task automatic wait_drained();
      @(negedge clock);
      while (frames_taken != frames_queued || pending_cmds.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic check_response(input logic [rcm_pkg::TDATA_W-1:0] got);
      rcm_pkg::cmd_type want;
      if (pending_cmds.size() == 0) begin
         report_error($sformatf("response with nothing pending: %h", got));
      end else begin
         want = pending_cmds.pop_front();
         for (int k = 0; k < 8; k++) begin
            if (got[16*k +: 16] !== want[16*k +: 16]) begin
               report_error($sformatf("%s got %0d expected %0d", cmd_names[k],
                  $signed(got[16*k +: 16]), $signed(want[16*k +: 16])));
            end
         end
      end
   endtask

   // request side
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_frame = frames_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_frame.pulses;
            req_tuser  <= next_frame.link;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side, with an occasional long hold-off
   always @(negedge clock) begin
      if (stall_ask != stall_ack) begin
         stall_ack  <= stall_ask;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL rc_stick_channel_mapper_core");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
         req_fire <= !reset && req_tvalid && req_tready;
         if (!reset && req_tvalid && req_tready) begin
            pending_cmds.push_back(map_frame(req_tdata, req_tuser));
            frames_taken <= frames_taken + 1;
         end
         if (!reset && rsp_tvalid && rsp_tready) check_response(rsp_tdata);
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset config: AETR, band 4
      add_frame({8{16'd1500}}, 1'b1);
      add_frame({8{16'd1000}}, 1'b1);
      add_frame({8{16'd2000}}, 1'b1);
      add_frame({8{16'd0}}, 1'b1);
      add_frame({8{16'hFFFF}}, 1'b1);
      add_frame({8{16'h8000}}, 1'b1);
      add_frame({8{16'd1496}}, 1'b1);
      add_frame({8{16'd1497}}, 1'b1);
      add_frame({8{16'd1503}}, 1'b1);
      add_frame({8{16'd1504}}, 1'b1);
      add_frame({8{16'd1499}}, 1'b1);
      add_frame({8{16'd1501}}, 1'b1);
      add_frame({8{16'd999}}, 1'b1);
      add_frame({8{16'd1001}}, 1'b1);
      add_frame({8{16'd1999}}, 1'b1);
      add_frame({8{16'd2001}}, 1'b1);
      add_frame({8{16'd1250}}, 1'b1);
      add_frame({8{16'd1750}}, 1'b1);
      add_frame({16'd2000, 16'd1000, 16'd1750, 16'd1250,
                 16'd1503, 16'd1497, 16'd2001, 16'd999}, 1'b1);
      // failsafe, with centered and with odd pulses
      add_frame({8{16'd1500}}, 1'b0);
      add_frame({16'hFFFF, 16'd0, 16'd1750, 16'd1250,
                 16'd2000, 16'd1000, 16'h5555, 16'hAAAA}, 1'b0);
      add_random_frames(80);
      wait_drained();

      // each phase boundary also pauses the sender until all commands are back
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_csr(rcm_pkg::CSR_CHANNEL_MAP, {7'($urandom), phase_map[ph]});
         write_csr(rcm_pkg::CSR_DEADBAND_US, phase_band[ph]);
         send_idle_pct = phase_send_idle[ph];
         stall_pct = phase_stall[ph];
         add_random_frames(85);
         // sender keeps offering while the receiver holds off: fills the pipe
         if (ph == 3) stall_ask = ~stall_ask;
         wait_drained();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (pending_cmds.size() != 0) begin
         report_error($sformatf("%0d commands never arrived", pending_cmds.size()));
      end
      if (error_count == 0) begin
         $display("PASS rc_stick_channel_mapper_core");
      end else begin
         $display("FAIL rc_stick_channel_mapper_core");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rcm_pkg.sv
hw/rtl/rcm_norm_bi.sv
hw/rtl/rcm_norm_uni.sv
hw/rtl/rcm_frame_map.sv
hw/rtl/rc_stick_channel_mapper_core.sv
hw/rtl/rcm_checker.sv
tb/tb_rc_stick_channel_mapper_core.sv
